// ===== rtl/sws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window sender package
// Shared operation codes, field widths and the request type that travels
// from the front end to the window engine.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int SEQ_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int TICK_W   = 20;
  localparam int MAX_OUT  = 16;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd1000;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_LIST = 2'd3
  } op_t;

  typedef enum logic {
    CFG_INITIAL_BASE  = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                 op;
    logic [SEQ_W-1:0]    seq_no;
    logic [HANDLE_W-1:0] pkt_handle;
    logic [SEQ_W-1:0]    ack_no;
  } req_t;

endpackage
`default_nettype wire

// ===== rtl/sws_req_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window sender request queue
// Two-entry queue that decouples request intake from the window engine.
// ----------------------------------------------------------------------------
module sws_req_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sws_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sws_pkg::req_t      out_req
);
  import sws_pkg::*;

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_req   = mem[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sws_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window sender engine
// Holds the window slots, base and timer, and carries out each request.
// ----------------------------------------------------------------------------
module sws_engine #(
  parameter int WINDOW = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire sws_pkg::req_t                req,
  input  wire logic                         base_load,
  input  wire logic [sws_pkg::SEQ_W-1:0]    base_value,
  input  wire logic [sws_pkg::TICK_W-1:0]   timeout_ticks,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic [1:0]                        kind,
  output logic                              flag,
  output logic [sws_pkg::SEQ_W-1:0]         base_seq,
  output logic                              timer_on,
  output logic [sws_pkg::SEQ_W-1:0]         entry_seq,
  output logic [sws_pkg::HANDLE_W-1:0]      entry_handle,
  output logic                              entry_valid,
  output logic                              last
);
  import sws_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_OUT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK_SCAN,
    S_ACK_MIN,
    S_LIST,
    S_OUT
  } state_t;

  state_t              state;
  req_t                cur;
  logic [WINDOW-1:0]   slot_used;
  logic [SEQ_W-1:0]    slot_seq [WINDOW];
  logic [HANDLE_W-1:0] slot_handle [WINDOW];
  logic [SEQ_W-1:0]    window_base;
  logic                timer_running;
  logic [TICK_W-1:0]   elapsed_ticks;
  logic [WINDOW-1:0]   remaining;
  logic [WINDOW-1:0]   list_mask;
  logic [IDX_W-1:0]    scan_idx;
  logic [SEQ_W-1:0]    lowest;
  logic                any_left;
  logic                removed;
  logic [CNT_W-1:0]    list_cnt;

  logic [WINDOW-1:0]   match_vec;
  logic [WINDOW-1:0]   le_vec;
  logic                dup;
  logic                have_free;
  logic [IDX_W-1:0]    free_idx;
  logic                list_any;
  logic [IDX_W-1:0]    list_idx;
  logic [WINDOW-1:0]   list_after;
  logic                out_free;
  logic                res_load;
  logic [SEQ_W-1:0]    ack_limit;
  logic [TICK_W-1:0]   tick_next;

  assign ack_limit = cur.ack_no - 32'd1;
  assign out_free  = !res_valid || res_ready;
  assign res_load  = ((state == S_LIST) || (state == S_OUT)) && out_free;
  assign req_ready = (state == S_IDLE);
  assign tick_next = (elapsed_ticks != TICK_MAX) ? elapsed_ticks + 1'b1 : elapsed_ticks;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      match_vec[i] = slot_used[i] && (slot_seq[i] == cur.seq_no);
      le_vec[i]    = slot_used[i] && (slot_seq[i] <= ack_limit);
    end
    dup = |match_vec;
  end

  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        have_free = 1'b1;
        free_idx  = IDX_W'(i);
      end
    end
  end

  always_comb begin
    list_any = 1'b0;
    list_idx = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (list_mask[i]) begin
        list_any = 1'b1;
        list_idx = IDX_W'(i);
      end
    end
    list_after = list_mask;
    list_after[list_idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cur <= req;
    end
    if (state == S_OUT && cur.op == OP_ADD && !dup && have_free) begin
      slot_seq[free_idx]    <= cur.seq_no;
      slot_handle[free_idx] <= cur.pkt_handle;
    end
    if (state == S_LIST && out_free && list_any) begin
      entry_seq    <= slot_seq[list_idx];
      entry_handle <= slot_handle[list_idx];
    end else if (state == S_LIST && out_free) begin
      entry_seq    <= '0;
      entry_handle <= '0;
    end else if (state == S_OUT && out_free) begin
      entry_seq    <= '0;
      entry_handle <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_used     <= '0;
      window_base   <= '0;
      timer_running <= 1'b0;
      elapsed_ticks <= '0;
      res_valid     <= 1'b0;
      kind          <= OP_ADD;
      flag          <= 1'b0;
      base_seq      <= '0;
      timer_on      <= 1'b0;
      entry_valid   <= 1'b0;
      last          <= 1'b0;
      remaining     <= '0;
      list_mask     <= '0;
      scan_idx      <= '0;
      lowest        <= '0;
      any_left      <= 1'b0;
      removed       <= 1'b0;
      list_cnt      <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (base_load) begin
        window_base <= base_value;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            case (req.op)
              OP_ACK: begin
                state <= S_ACK_SCAN;
              end
              OP_LIST: begin
                list_mask <= slot_used;
                list_cnt  <= '0;
                state     <= S_LIST;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_ACK_SCAN: begin
          remaining <= slot_used & ~le_vec;
          removed   <= |le_vec;
          any_left  <= 1'b0;
          lowest    <= '0;
          scan_idx  <= '0;
          state     <= (slot_used == '0) ? S_OUT : S_ACK_MIN;
        end
        S_ACK_MIN: begin
          if (remaining[scan_idx] && (!any_left || slot_seq[scan_idx] < lowest)) begin
            lowest   <= slot_seq[scan_idx];
            any_left <= 1'b1;
          end
          if (32'(scan_idx) == WINDOW - 1) begin
            slot_used <= remaining;
            state     <= S_OUT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_LIST: begin
          if (out_free) begin
            kind        <= OP_LIST;
            flag        <= 1'b0;
            base_seq    <= window_base;
            timer_on    <= timer_running;
            entry_valid <= list_any;
            list_mask   <= list_after;
            list_cnt    <= list_cnt + 1'b1;
            if (!list_any || list_after == '0 || 32'(list_cnt) == MAX_OUT - 1) begin
              last  <= 1'b1;
              state <= S_IDLE;
            end else begin
              last <= 1'b0;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            kind        <= cur.op;
            entry_valid <= 1'b0;
            last        <= 1'b1;
            state       <= S_IDLE;
            case (cur.op)
              OP_ADD: begin
                flag     <= !dup && have_free;
                base_seq <= window_base;
                if (!dup && have_free) begin
                  slot_used[free_idx] <= 1'b1;
                  timer_on            <= 1'b1;
                  if (!timer_running) begin
                    timer_running <= 1'b1;
                    elapsed_ticks <= '0;
                  end
                end else begin
                  timer_on <= timer_running;
                end
              end
              OP_ACK: begin
                if (slot_used == '0 && !removed && !any_left && remaining == '0) begin
                  flag     <= 1'b0;
                  base_seq <= window_base;
                  timer_on <= timer_running;
                end else begin
                  flag <= removed;
                  if (any_left) begin
                    window_base   <= lowest;
                    base_seq      <= lowest;
                    timer_running <= 1'b1;
                    elapsed_ticks <= '0;
                    timer_on      <= 1'b1;
                  end else begin
                    window_base   <= cur.ack_no;
                    base_seq      <= cur.ack_no;
                    timer_running <= 1'b0;
                    timer_on      <= 1'b0;
                  end
                end
              end
              default: begin
                base_seq <= window_base;
                timer_on <= timer_running;
                if (timer_running) begin
                  elapsed_ticks <= tick_next;
                  flag          <= (tick_next >= timeout_ticks);
                end else begin
                  flag <= 1'b0;
                end
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sliding_window_sender_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Add and tick pass through the engine's output state; an ack first passes a
// scan state and, if the window holds slots, a search for the lowest number
// that checks one slot a cycle. A retransmit request lists one entry per cycle
// while the output is not stalled. The engine takes a new request only when idle;
// a two-entry queue takes requests while it works. Synchronous reset empties the window.
// ----------------------------------------------------------------------------
// Sliding window sender core
// Front queue, configuration registers and the window engine.
// ----------------------------------------------------------------------------
module sliding_window_sender_core #(
  parameter int WINDOW = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: seq_no[31:0], pkt_handle[47:32], ack_no[79:48]
  input  wire logic [79:0] s_axis_tdata,
  // tuser: op[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: flag[0], base_seq[32:1], timer_on[33], entry_seq[65:34],
  // entry_handle[81:66], entry_valid[82], zeros
  output logic [87:0]      m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import sws_pkg::*;

  req_t                in_req;
  req_t                q_req;
  logic                q_valid;
  logic                q_ready;
  logic [TICK_W-1:0]   timeout_ticks;
  logic                base_load;
  logic                flag;
  logic [SEQ_W-1:0]    base_seq;
  logic                timer_on;
  logic [SEQ_W-1:0]    entry_seq;
  logic [HANDLE_W-1:0] entry_handle;
  logic                entry_valid;

  assign in_req.op         = op_t'(s_axis_tuser);
  assign in_req.seq_no     = s_axis_tdata[31:0];
  assign in_req.pkt_handle = s_axis_tdata[47:32];
  assign in_req.ack_no     = s_axis_tdata[79:48];

  assign cfg_ready = 1'b1;
  assign base_load = cfg_valid && (cfg_index == CFG_INITIAL_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_index == CFG_TIMEOUT_TICKS) begin
      timeout_ticks <= cfg_data[TICK_W-1:0];
    end
  end

  sws_req_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (in_req),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_req   (q_req)
  );

  sws_engine #(
    .WINDOW (WINDOW)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (q_valid),
    .req_ready     (q_ready),
    .req           (q_req),
    .base_load     (base_load),
    .base_value    (cfg_data),
    .timeout_ticks (timeout_ticks),
    .res_valid     (m_axis_tvalid),
    .res_ready     (m_axis_tready),
    .kind          (m_axis_tuser),
    .flag          (flag),
    .base_seq      (base_seq),
    .timer_on      (timer_on),
    .entry_seq     (entry_seq),
    .entry_handle  (entry_handle),
    .entry_valid   (entry_valid),
    .last          (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b00000, entry_valid, entry_handle, entry_seq, timer_on,
                         base_seq, flag};

endmodule
`default_nettype wire
